FILE: sv/mvcc_pkg.sv
// Shared types and constants for the row version manager.
// No dependencies; imported by every module of the block.
`default_nettype none
package mvcc_pkg;

	localparam int HIST_DEPTH = 8;
	localparam int WAIT_DEPTH = 8;
	localparam int TS_W       = 48;
	localparam int TXN_W      = 6;
	localparam int SLOT_W     = $clog2(HIST_DEPTH);
	localparam int WIDX_W     = $clog2(WAIT_DEPTH);
	localparam int VSLOT_W    = 4;
	localparam int CNT_W      = 4;
	localparam int IN_W       = 104;
	localparam int OUT_W      = 16;

	localparam logic [VSLOT_W-1:0] BASE_SLOT = VSLOT_W'(HIST_DEPTH);

	typedef enum logic [1:0] {
		OP_READ     = 2'd0,
		OP_PREWRITE = 2'd1,
		OP_WRITE    = 2'd2,
		OP_ABORT    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_WAIT   = 2'd1,
		STAT_ABORT  = 2'd2,
		STAT_REJECT = 2'd3
	} stat_t;

	typedef struct packed {
		logic               wake;
		logic [TXN_W-1:0]   txn;
		stat_t              status;
		logic [VSLOT_W-1:0] slot;
	} res_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_RD_OLD,
		S_RD_NEW,
		S_RD_PEND,
		S_RD_MAX,
		S_RD_SCAN_A,
		S_RD_SCAN_B,
		S_PW_NEW,
		S_PW_MAX,
		S_PW_PEND,
		S_BUF,
		S_WR_CHK,
		S_RL_A,
		S_RL_B,
		S_RW_A,
		S_RW_B,
		S_GC_CHK,
		S_GC1_A,
		S_GC1_B,
		S_GC2,
		S_FREE,
		S_RCY,
		S_RSV_END,
		S_PUSH,
		S_FLUSH
	} seq_state_t;

endpackage
`default_nettype wire

FILE: sv/mvcc_cmp.sv
// Shared timestamp comparator used by the sequencer every cycle.
// Depends on mvcc_pkg.
`default_nettype none
module mvcc_cmp
	import mvcc_pkg::*;
(
	input  wire logic [TS_W-1:0] a,
	input  wire logic [TS_W-1:0] b,
	output logic                 lt,
	output logic                 eq
);

	assign lt = a < b;
	assign eq = a == b;

endmodule
`default_nettype wire

FILE: sv/mvcc_obuf.sv
// Output register for result words on the master stream side.
// Depends on mvcc_pkg.
`default_nettype none
module mvcc_obuf
	import mvcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire res_t             res,
	input  wire logic             res_last,
	output logic                  free,
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // txn_out[5:0], status[7:6], version_slot[11:8]
	output logic [0:0]            m_tuser,  // is_wakeup[0]
	output logic                  m_tlast
);

	logic valid_q;
	res_t res_q;
	logic last_q;

	assign free = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q  <= res;
			last_q <= res_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {4'd0, res_q.slot, res_q.status, res_q.txn};
	assign m_tuser  = res_q.wake;
	assign m_tlast  = last_q;

endmodule
`default_nettype wire

FILE: sv/mvcc_row_version_manager_core.sv
// Top level: request sequencer, version history, wait buffer and result hold.
// Depends on mvcc_pkg, mvcc_cmp and mvcc_obuf.
//
// One request is taken at a time. Every timestamp test goes through a single
// shared comparator, one compare per cycle while the result port does not
// stall, so the checks of a request and its scans over history slots or wait
// entries run one after another. A prewrite may reclaim or recycle history. A
// commit or abort of the pending prewrite releases waiting reads and at most
// one waiting prewrite. Stalls on the result port hold the sequencer. s_tready
// is high only while idle.
`default_nettype none
module mvcc_row_version_manager_core
	import mvcc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             s_tvalid,
	output logic                  s_tready,
	input  wire logic [IN_W-1:0]  s_tdata,  // ts[47:0], txn_id[53:48], min_active_ts[101:54]
	input  wire logic [1:0]       s_tuser,  // op[1:0]
	output logic                  m_tvalid,
	input  wire logic             m_tready,
	output logic [OUT_W-1:0]      m_tdata,  // txn_out[5:0], status[7:6], version_slot[11:8]
	output logic [0:0]            m_tuser,  // is_wakeup[0]
	output logic                  m_tlast
);

	seq_state_t state_q, state_d, ret_q, ret_d;

	op_t               op_q, op_d;
	logic [TS_W-1:0]   ts_q, ts_d, min_q, min_d;
	logic [TXN_W-1:0]  txn_q, txn_d;
	logic [SLOT_W-1:0] sidx_q, sidx_d, rsv_idx_q, rsv_idx_d;
	logic [WIDX_W-1:0] widx_q, widx_d;
	logic [TS_W-1:0]   best_q, best_d, next_q, next_d;
	logic [VSLOT_W-1:0] pick_q, pick_d;
	logic found_q, found_d, have_q, have_d, relpw_q, relpw_d, rsv_rel_q, rsv_rel_d;
	res_t new_q, new_d, hold_q, hold_d;
	logic hold_v_q, hold_v_d;

	logic [HIST_DEPTH-1:0] sv_q, sv_d, sr_q, sr_d, sa_q, sa_d;
	logic [TS_W-1:0]       slot_ts_q [HIST_DEPTH];
	logic [TS_W-1:0]       slot_ts_d [HIST_DEPTH];
	logic [WAIT_DEPTH-1:0] wv_q, wv_d, wpw_q, wpw_d;
	logic [TS_W-1:0]       wts_q [WAIT_DEPTH];
	logic [TS_W-1:0]       wts_d [WAIT_DEPTH];
	logic [TXN_W-1:0]      wtxn_q [WAIT_DEPTH];
	logic [TXN_W-1:0]      wtxn_d [WAIT_DEPTH];
	logic [TS_W-1:0]       newest_q, newest_d, oldest_q, oldest_d, maxrd_q, maxrd_d;
	logic                  pend_q, pend_d;
	logic [TS_W-1:0]       pend_ts_q, pend_ts_d;
	logic [SLOT_W-1:0]     pend_slot_q, pend_slot_d;
	logic [CNT_W-1:0]      vcnt_q, vcnt_d;
	logic [VSLOT_W-1:0]    nslot_q, nslot_d;

	logic [TS_W-1:0] cmp_a, cmp_b;
	logic            cmp_lt, cmp_eq;
	logic            ob_load, ob_free;

	logic [SLOT_W-1:0] fidx;
	logic              ffound, fbrk;
	logic [WIDX_W-1:0] wfidx;
	logic              wfok;
	logic [TS_W-1:0]   cur_sts, cur_wts, rsv_ts;
	logic              s_last, w_last, hist_full;

	mvcc_cmp u_cmp (.a(cmp_a), .b(cmp_b), .lt(cmp_lt), .eq(cmp_eq));

	mvcc_obuf u_obuf (
		.clk(clk), .arst_n(arst_n), .load(ob_load), .res(hold_q),
		.res_last(state_q == S_FLUSH), .free(ob_free),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast)
	);

	assign cur_sts   = slot_ts_q[sidx_q];
	assign cur_wts   = wts_q[widx_q];
	assign rsv_ts    = rsv_rel_q ? cur_wts : ts_q;
	assign s_last    = sidx_q == SLOT_W'(HIST_DEPTH - 1);
	assign w_last    = widx_q == WIDX_W'(WAIT_DEPTH - 1);
	assign hist_full = vcnt_q == CNT_W'(HIST_DEPTH);
	assign s_tready  = state_q == S_IDLE;

	// free slot: first free one that was allocated before, else last free one
	always_comb begin
		fidx   = '0;
		ffound = 1'b0;
		fbrk   = 1'b0;
		for (int i = 0; i < HIST_DEPTH; i++) begin
			if (!sv_q[i] && !sr_q[i] && !fbrk) begin
				fidx   = SLOT_W'(i);
				ffound = 1'b1;
				if (sa_q[i]) fbrk = 1'b1;
			end
		end
	end

	always_comb begin
		wfidx = '0;
		wfok  = 1'b0;
		for (int i = WAIT_DEPTH - 1; i >= 0; i--) begin
			if (!wv_q[i]) begin
				wfidx = WIDX_W'(i);
				wfok  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;  ret_d = ret_q;
		op_d = op_q;  ts_d = ts_q;  min_d = min_q;  txn_d = txn_q;
		sidx_d = sidx_q;  widx_d = widx_q;  rsv_idx_d = rsv_idx_q;
		best_d = best_q;  next_d = next_q;  pick_d = pick_q;
		found_d = found_q;  have_d = have_q;  relpw_d = relpw_q;  rsv_rel_d = rsv_rel_q;
		new_d = new_q;  hold_d = hold_q;  hold_v_d = hold_v_q;
		sv_d = sv_q;  sr_d = sr_q;  sa_d = sa_q;  slot_ts_d = slot_ts_q;
		wv_d = wv_q;  wpw_d = wpw_q;  wts_d = wts_q;  wtxn_d = wtxn_q;
		newest_d = newest_q;  oldest_d = oldest_q;  maxrd_d = maxrd_q;
		pend_d = pend_q;  pend_ts_d = pend_ts_q;  pend_slot_d = pend_slot_q;
		vcnt_d = vcnt_q;  nslot_d = nslot_q;
		cmp_a = ts_q;  cmp_b = ts_q;
		ob_load = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					op_d  = op_t'(s_tuser);
					ts_d  = s_tdata[47:0];
					txn_d = s_tdata[53:48];
					min_d = s_tdata[101:54];
					widx_d = '0;  have_d = 1'b0;  next_d = '0;  relpw_d = 1'b0;
					unique case (op_t'(s_tuser))
						OP_READ:     state_d = S_RD_OLD;
						OP_PREWRITE: state_d = S_PW_NEW;
						OP_WRITE:    state_d = S_WR_CHK;
						OP_ABORT: begin
							if (!pend_q) begin
								new_d = '{1'b0, s_tdata[53:48], STAT_REJECT, '0};
								ret_d = S_FLUSH;
							end else begin
								sv_d[pend_slot_q] = 1'b0;
								sr_d[pend_slot_q] = 1'b0;
								pend_d = 1'b0;
								new_d = '{1'b0, s_tdata[53:48], STAT_OK, VSLOT_W'(pend_slot_q)};
								ret_d = S_RL_A;
							end
							state_d = S_PUSH;
						end
					endcase
				end
			end
			S_RD_OLD: begin
				cmp_a = ts_q;  cmp_b = oldest_q;
				if (cmp_lt) begin
					new_d = '{1'b0, txn_q, STAT_ABORT, '0};
					ret_d = S_FLUSH;  state_d = S_PUSH;
				end else begin
					state_d = S_RD_NEW;
				end
			end
			S_RD_NEW: begin
				cmp_a = newest_q;  cmp_b = ts_q;
				if (cmp_lt) begin
					state_d = S_RD_PEND;
				end else begin
					sidx_d = '0;  best_d = '0;  pick_d = nslot_q;
					state_d = S_RD_SCAN_A;
				end
			end
			S_RD_PEND: begin
				cmp_a = pend_ts_q;  cmp_b = ts_q;
				state_d = (pend_q && cmp_lt) ? S_BUF : S_RD_MAX;
			end
			S_RD_MAX: begin
				cmp_a = maxrd_q;  cmp_b = ts_q;
				if (cmp_lt) maxrd_d = ts_q;
				new_d = '{1'b0, txn_q, STAT_OK, nslot_q};
				ret_d = S_FLUSH;  state_d = S_PUSH;
			end
			S_RD_SCAN_A, S_RD_SCAN_B: begin
				if (state_q == S_RD_SCAN_A) begin
					cmp_a = cur_sts;  cmp_b = ts_q;
				end else begin
					cmp_a = best_q;  cmp_b = cur_sts;
					if (cmp_lt) begin
						best_d = cur_sts;
						pick_d = VSLOT_W'(sidx_q);
					end
				end
				if (state_q == S_RD_SCAN_A && sv_q[sidx_q] && cmp_lt) begin
					state_d = S_RD_SCAN_B;
				end else if (s_last) begin
					new_d = '{1'b0, txn_q, STAT_OK, pick_d};
					ret_d = S_FLUSH;  state_d = S_PUSH;
				end else begin
					sidx_d = sidx_q + 1'b1;
					state_d = S_RD_SCAN_A;
				end
			end
			S_PW_NEW, S_PW_MAX, S_PW_PEND: begin
				cmp_a = ts_q;
				cmp_b = (state_q == S_PW_NEW) ? newest_q :
				        (state_q == S_PW_MAX) ? maxrd_q : pend_ts_q;
				if (cmp_lt && (state_q != S_PW_PEND || pend_q)) begin
					new_d = '{1'b0, txn_q, STAT_ABORT, '0};
					ret_d = S_FLUSH;  state_d = S_PUSH;
				end else if (state_q == S_PW_NEW) begin
					state_d = S_PW_MAX;
				end else if (state_q == S_PW_MAX) begin
					state_d = S_PW_PEND;
				end else if (pend_q) begin
					state_d = S_BUF;
				end else begin
					rsv_rel_d = 1'b0;
					state_d = S_GC_CHK;
				end
			end
			S_BUF: begin
				if (wfok) begin
					wv_d[wfidx]   = 1'b1;
					wpw_d[wfidx]  = op_q == OP_PREWRITE;
					wts_d[wfidx]  = ts_q;
					wtxn_d[wfidx] = txn_q;
					new_d = '{1'b0, txn_q, STAT_WAIT, '0};
				end else begin
					new_d = '{1'b0, txn_q, STAT_ABORT, '0};
				end
				ret_d = S_FLUSH;  state_d = S_PUSH;
			end
			S_WR_CHK: begin
				cmp_a = newest_q;  cmp_b = ts_q;
				if (!pend_q || !cmp_lt) begin
					new_d = '{1'b0, txn_q, STAT_REJECT, '0};
					ret_d = S_FLUSH;
				end else begin
					sv_d[pend_slot_q] = 1'b1;
					slot_ts_d[pend_slot_q] = ts_q;
					newest_d = ts_q;
					nslot_d = VSLOT_W'(pend_slot_q);
					pend_d = 1'b0;
					if (!hist_full) vcnt_d = vcnt_q + 1'b1;
					new_d = '{1'b0, txn_q, STAT_OK, VSLOT_W'(pend_slot_q)};
					ret_d = S_RL_A;
				end
				state_d = S_PUSH;
			end
			S_RL_A, S_RL_B: begin
				if (state_q == S_RL_A) begin
					cmp_a = ts_q;  cmp_b = cur_wts;
				end else begin
					cmp_a = cur_wts;  cmp_b = next_q;
					if (!have_q || cmp_lt) begin
						next_d = cur_wts;
						have_d = 1'b1;
					end
				end
				if (state_q == S_RL_A && wv_q[widx_q] && wpw_q[widx_q] && cmp_lt) begin
					state_d = S_RL_B;
				end else if (w_last) begin
					widx_d = '0;
					state_d = S_RW_A;
				end else begin
					widx_d = widx_q + 1'b1;
					state_d = S_RL_A;
				end
			end
			S_RW_A: begin
				cmp_a = cur_wts;  cmp_b = next_q;
				if (wv_q[widx_q] && !wpw_q[widx_q] && (!have_q || cmp_lt)) begin
					state_d = S_RW_B;
				end else if (wv_q[widx_q] && wpw_q[widx_q] && have_q && !relpw_q && cmp_eq) begin
					relpw_d = 1'b1;
					wv_d[widx_q] = 1'b0;
					rsv_rel_d = 1'b1;
					state_d = S_GC_CHK;
				end else if (w_last) begin
					state_d = S_FLUSH;
				end else begin
					widx_d = widx_q + 1'b1;
				end
			end
			S_RW_B: begin
				cmp_a = maxrd_q;  cmp_b = cur_wts;
				if (cmp_lt) maxrd_d = cur_wts;
				wv_d[widx_q] = 1'b0;
				new_d = '{1'b1, wtxn_q[widx_q], STAT_OK, nslot_q};
				if (w_last) begin
					ret_d = S_FLUSH;
				end else begin
					widx_d = widx_q + 1'b1;
					ret_d = S_RW_A;
				end
				state_d = S_PUSH;
			end
			S_GC_CHK: begin
				cmp_a = oldest_q;  cmp_b = min_q;
				sidx_d = '0;  best_d = '0;  found_d = 1'b0;
				state_d = (cmp_lt && hist_full) ? S_GC1_A : S_FREE;
			end
			S_GC1_A, S_GC1_B: begin
				if (state_q == S_GC1_A) begin
					cmp_a = cur_sts;  cmp_b = min_q;
				end else begin
					cmp_a = best_q;  cmp_b = cur_sts;
					if (cmp_lt) begin
						best_d = cur_sts;
						found_d = 1'b1;
					end
				end
				if (state_q == S_GC1_A && sv_q[sidx_q] && cmp_lt) begin
					state_d = S_GC1_B;
				end else if (s_last) begin
					sidx_d = '0;
					if (found_d) begin
						oldest_d = best_d;
						state_d = S_GC2;
					end else begin
						state_d = S_FREE;
					end
				end else begin
					sidx_d = sidx_q + 1'b1;
					state_d = S_GC1_A;
				end
			end
			S_GC2: begin
				cmp_a = best_q;  cmp_b = cur_sts;
				if (sv_q[sidx_q] && !cmp_lt) begin
					sv_d[sidx_q] = 1'b0;
					sr_d[sidx_q] = 1'b0;
					if (nslot_q == VSLOT_W'(sidx_q)) nslot_d = BASE_SLOT;
					if (vcnt_q != '0) vcnt_d = vcnt_q - 1'b1;
				end
				if (s_last) begin
					state_d = S_FREE;
				end else begin
					sidx_d = sidx_q + 1'b1;
				end
			end
			S_FREE: begin
				if (!hist_full && ffound) begin
					rsv_idx_d = fidx;
					state_d = S_RSV_END;
				end else begin
					sidx_d = '0;  found_d = 1'b0;  rsv_idx_d = '0;
					state_d = S_RCY;
				end
			end
			S_RCY: begin
				cmp_a = cur_sts;  cmp_b = best_q;
				if (sv_q[sidx_q] && (!found_q || cmp_lt)) begin
					best_d = cur_sts;
					rsv_idx_d = sidx_q;
					found_d = 1'b1;
				end
				if (s_last) begin
					if (found_d) begin
						oldest_d = best_d;
						if (vcnt_q != '0) vcnt_d = vcnt_q - 1'b1;
					end
					if (nslot_q == VSLOT_W'(rsv_idx_d)) nslot_d = BASE_SLOT;
					state_d = S_RSV_END;
				end else begin
					sidx_d = sidx_q + 1'b1;
				end
			end
			S_RSV_END: begin
				sa_d[rsv_idx_q] = 1'b1;
				sv_d[rsv_idx_q] = 1'b0;
				sr_d[rsv_idx_q] = 1'b1;
				slot_ts_d[rsv_idx_q] = rsv_ts;
				pend_d = 1'b1;
				pend_slot_d = rsv_idx_q;
				pend_ts_d = rsv_ts;
				if (rsv_rel_q) begin
					new_d = '{1'b1, wtxn_q[widx_q], STAT_OK, VSLOT_W'(rsv_idx_q)};
					if (w_last) begin
						ret_d = S_FLUSH;
					end else begin
						widx_d = widx_q + 1'b1;
						ret_d = S_RW_A;
					end
				end else begin
					new_d = '{1'b0, txn_q, STAT_OK, VSLOT_W'(rsv_idx_q)};
					ret_d = S_FLUSH;
				end
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (!hold_v_q || ob_free) begin
					ob_load = hold_v_q;
					hold_d = new_q;
					hold_v_d = 1'b1;
					state_d = ret_q;
				end
			end
			S_FLUSH: begin
				if (ob_free) begin
					ob_load = 1'b1;
					hold_v_d = 1'b0;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			sv_q <= '0;  sr_q <= '0;  sa_q <= '0;  wv_q <= '0;
			newest_q <= '0;  oldest_q <= '0;  maxrd_q <= '0;
			pend_q <= 1'b0;  pend_ts_q <= '0;  pend_slot_q <= '0;
			vcnt_q <= '0;  nslot_q <= BASE_SLOT;
			ret_q <= S_IDLE;
		end else begin
			hold_v_q <= hold_v_d;
			sv_q <= sv_d;  sr_q <= sr_d;  sa_q <= sa_d;  wv_q <= wv_d;
			newest_q <= newest_d;  oldest_q <= oldest_d;  maxrd_q <= maxrd_d;
			pend_q <= pend_d;  pend_ts_q <= pend_ts_d;  pend_slot_q <= pend_slot_d;
			vcnt_q <= vcnt_d;  nslot_q <= nslot_d;
			ret_q <= ret_d;
		end
	end

	always_ff @(posedge clk) begin
		op_q <= op_d;  ts_q <= ts_d;  min_q <= min_d;  txn_q <= txn_d;
		sidx_q <= sidx_d;  widx_q <= widx_d;  rsv_idx_q <= rsv_idx_d;
		best_q <= best_d;  next_q <= next_d;  pick_q <= pick_d;
		found_q <= found_d;  have_q <= have_d;  relpw_q <= relpw_d;
		rsv_rel_q <= rsv_rel_d;
		new_q <= new_d;  hold_q <= hold_d;
		slot_ts_q <= slot_ts_d;
		wpw_q <= wpw_d;  wts_q <= wts_d;  wtxn_q <= wtxn_d;
	end

`ifndef ASSERT_OFF
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !hold_v_q)
		else $error("request taken while a result is still held");

	a_pend_reserved: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> sr_q[pend_slot_q])
		else $error("pending prewrite slot not reserved");

	a_vcnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		vcnt_q <= CNT_W'(HIST_DEPTH))
		else $error("version count above history depth");

	a_flush_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |-> hold_v_q)
		else $error("final word sent with nothing held");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_mvcc_row_version_manager_core.sv
// Testbench for mvcc_row_version_manager_core: requests on the slave stream,
// results checked against an in-bench model of the row version manager.
// Depends on mvcc_pkg and the RTL of the block.
`default_nettype none
module tb_mvcc_row_version_manager_core;
	import mvcc_pkg::*;

	typedef struct packed {
		op_t            op;
		logic [TS_W-1:0] ts;
		logic [TXN_W-1:0] txn;
		logic [TS_W-1:0] min_ts;
	} req_t;

	typedef struct packed {
		logic            wake;
		logic [TXN_W-1:0] txn;
		stat_t           status;
		logic [VSLOT_W-1:0] slot;
		logic            last;
	} reply_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	logic [0:0] m_tuser;
	logic m_tlast;

	mvcc_row_version_manager_core i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// model state
	logic            h_valid [HIST_DEPTH];
	logic            h_rsv [HIST_DEPTH];
	logic            h_alloc [HIST_DEPTH];
	logic [TS_W-1:0] h_ts [HIST_DEPTH];
	logic            w_valid [WAIT_DEPTH];
	logic            w_pw [WAIT_DEPTH];
	logic [TS_W-1:0] w_ts [WAIT_DEPTH];
	logic [TXN_W-1:0] w_txn [WAIT_DEPTH];
	logic [TS_W-1:0] newest_wts, oldest_wts, max_rts, pend_ts;
	logic            pend;
	int              pend_slot, ver_cnt, newest_slot;

	req_t   pending_reqs[$];
	reply_t expected_replies[$];
	int     errors = 0, n_words = 0, n_wakes = 0, cycles = 0;
	bit     stim_done = 0, quiet = 0;
	int     s_gap = 0, m_gap = 0;

	function automatic void clear_model();
		for (int i = 0; i < HIST_DEPTH; i++) begin
			h_valid[i] = 0; h_rsv[i] = 0; h_alloc[i] = 0; h_ts[i] = '0;
		end
		for (int i = 0; i < WAIT_DEPTH; i++) begin
			w_valid[i] = 0; w_pw[i] = 0; w_ts[i] = '0; w_txn[i] = '0;
		end
		newest_wts = '0; oldest_wts = '0; max_rts = '0; pend_ts = '0;
		pend = 0; pend_slot = 0; ver_cnt = 0; newest_slot = HIST_DEPTH;
	endfunction

	function automatic void push_reply(logic wk, logic [TXN_W-1:0] t, stat_t st, int sl);
		reply_t r;
		r.wake = wk; r.txn = t; r.status = st; r.slot = VSLOT_W'(sl); r.last = 0;
		expected_replies.push_back(r);
	endfunction

	function automatic bit enqueue_wait(logic pw, logic [TS_W-1:0] t, logic [TXN_W-1:0] x);
		for (int i = 0; i < WAIT_DEPTH; i++)
			if (!w_valid[i]) begin
				w_valid[i] = 1; w_pw[i] = pw; w_ts[i] = t; w_txn[i] = x;
				return 1;
			end
		return 0;
	endfunction

	function automatic int reserve_version(logic [TS_W-1:0] t, logic [TS_W-1:0] mts);
		int idx;
		bit found;
		logic [TS_W-1:0] best, low;
		idx = HIST_DEPTH;
		found = 0;
		best = '0;
		low = '0;
		if (oldest_wts < mts && ver_cnt == HIST_DEPTH) begin
			for (int i = 0; i < HIST_DEPTH; i++)
				if (h_valid[i] && h_ts[i] < mts && h_ts[i] > best) begin
					best = h_ts[i]; found = 1;
				end
			if (found) begin
				oldest_wts = best;
				for (int i = 0; i < HIST_DEPTH; i++)
					if (h_valid[i] && h_ts[i] <= best) begin
						h_valid[i] = 0; h_rsv[i] = 0;
						if (newest_slot == i) newest_slot = HIST_DEPTH;
						if (ver_cnt > 0) ver_cnt--;
					end
			end
		end
		if (ver_cnt < HIST_DEPTH)
			for (int i = 0; i < HIST_DEPTH; i++)
				if (!h_valid[i] && !h_rsv[i]) begin
					idx = i;
					if (h_alloc[i]) break;
				end
		if (idx == HIST_DEPTH) begin
			found = 0;
			for (int i = 0; i < HIST_DEPTH; i++)
				if (h_valid[i] && (!found || h_ts[i] < low)) begin
					low = h_ts[i]; idx = i; found = 1;
				end
			if (found) begin
				oldest_wts = low;
				if (ver_cnt > 0) ver_cnt--;
			end else
				idx = 0;
			if (newest_slot == idx) newest_slot = HIST_DEPTH;
		end
		h_alloc[idx] = 1; h_valid[idx] = 0; h_rsv[idx] = 1; h_ts[idx] = t;
		pend = 1; pend_slot = idx; pend_ts = t;
		return idx;
	endfunction

	function automatic void wake_waiters(logic [TS_W-1:0] t, logic [TS_W-1:0] mts);
		logic [TS_W-1:0] next_pw;
		bit have_next, done_pw;
		int s;
		next_pw = '0;
		have_next = 0;
		done_pw = 0;
		for (int i = 0; i < WAIT_DEPTH; i++)
			if (w_valid[i] && w_pw[i] && w_ts[i] > t && (!have_next || w_ts[i] < next_pw)) begin
				next_pw = w_ts[i]; have_next = 1;
			end
		for (int i = 0; i < WAIT_DEPTH; i++) begin
			if (!w_valid[i]) continue;
			if (!w_pw[i]) begin
				if (!have_next || w_ts[i] < next_pw) begin
					if (w_ts[i] > max_rts) max_rts = w_ts[i];
					w_valid[i] = 0;
					push_reply(1'b1, w_txn[i], STAT_OK, newest_slot);
				end
			end else if (have_next && !done_pw && w_ts[i] == next_pw) begin
				s = reserve_version(w_ts[i], mts);
				done_pw = 1;
				w_valid[i] = 0;
				push_reply(1'b1, w_txn[i], STAT_OK, s);
			end
		end
	endfunction

	function automatic void predict_request(req_t q);
		logic [TS_W-1:0] best;
		int pick, s, p;
		best = '0;
		pick = newest_slot;
		case (q.op)
			OP_READ: begin
				if (q.ts < oldest_wts)
					push_reply(1'b0, q.txn, STAT_ABORT, 0);
				else if (q.ts > newest_wts) begin
					if (pend && pend_ts < q.ts) begin
						if (enqueue_wait(1'b0, q.ts, q.txn))
							push_reply(1'b0, q.txn, STAT_WAIT, 0);
						else push_reply(1'b0, q.txn, STAT_ABORT, 0);
					end else begin
						if (q.ts > max_rts) max_rts = q.ts;
						push_reply(1'b0, q.txn, STAT_OK, newest_slot);
					end
				end else begin
					for (int i = 0; i < HIST_DEPTH; i++)
						if (h_valid[i] && h_ts[i] < q.ts && h_ts[i] > best) begin
							best = h_ts[i]; pick = i;
						end
					push_reply(1'b0, q.txn, STAT_OK, pick);
				end
			end
			OP_PREWRITE: begin
				if (q.ts < newest_wts || q.ts < max_rts || (pend && pend_ts > q.ts))
					push_reply(1'b0, q.txn, STAT_ABORT, 0);
				else if (pend) begin
					if (enqueue_wait(1'b1, q.ts, q.txn))
						push_reply(1'b0, q.txn, STAT_WAIT, 0);
					else push_reply(1'b0, q.txn, STAT_ABORT, 0);
				end else begin
					s = reserve_version(q.ts, q.min_ts);
					push_reply(1'b0, q.txn, STAT_OK, s);
				end
			end
			OP_WRITE: begin
				if (!pend || q.ts <= newest_wts)
					push_reply(1'b0, q.txn, STAT_REJECT, 0);
				else begin
					p = pend_slot % HIST_DEPTH;
					h_valid[p] = 1; h_ts[p] = q.ts;
					newest_wts = q.ts; newest_slot = p; pend = 0;
					if (ver_cnt < HIST_DEPTH) ver_cnt++;
					push_reply(1'b0, q.txn, STAT_OK, p);
					wake_waiters(q.ts, q.min_ts);
				end
			end
			default: begin
				if (!pend)
					push_reply(1'b0, q.txn, STAT_REJECT, 0);
				else begin
					p = pend_slot % HIST_DEPTH;
					h_valid[p] = 0; h_rsv[p] = 0; pend = 0;
					push_reply(1'b0, q.txn, STAT_OK, p);
					wake_waiters(q.ts, q.min_ts);
				end
			end
		endcase
		expected_replies[$].last = 1;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_request(pending_reqs.pop_front());
			end
			if (!(s_tvalid && !s_tready)) begin
				if (s_gap > 0) begin
					s_gap--;
					s_tvalid <= 0;
				end else if (pending_reqs.size() > (s_tvalid && s_tready ? 0 : 0) &&
					!(s_tvalid && s_tready && pending_reqs.size() == 0)) begin
					if (pending_reqs.size() > 0) begin
						s_tvalid <= 1;
						s_tuser <= pending_reqs[0].op;
						s_tdata <= {2'b0, pending_reqs[0].min_ts, pending_reqs[0].txn,
							pending_reqs[0].ts};
						if (!quiet && $urandom_range(0, 5) == 0) s_gap = $urandom_range(1, 12);
					end else
						s_tvalid <= 0;
				end else
					s_tvalid <= 0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		reply_t got, want;
		if (arst_n) begin
			cycles++;
			if (m_tvalid && m_tready) begin
				got.txn = m_tdata[5:0];
				got.status = stat_t'(m_tdata[7:6]);
				got.slot = m_tdata[11:8];
				got.wake = m_tuser[0];
				got.last = m_tlast;
				n_words++;
				if (got.wake) n_wakes++;
				if (expected_replies.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected word %p", got);
				end else begin
					want = expected_replies.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
					end
				end
			end
			if (m_gap > 0) begin
				m_gap--;
				m_tready <= 0;
			end else begin
				m_tready <= 1;
				if (!quiet && $urandom_range(0, 5) == 0) m_gap = $urandom_range(1, 12);
			end
		end
	end

	function automatic req_t mk(op_t o, logic [TS_W-1:0] t, logic [TXN_W-1:0] x,
		logic [TS_W-1:0] m);
		req_t r;
		r.op = o; r.ts = t; r.txn = x; r.min_ts = m;
		return r;
	endfunction

	function automatic logic [TS_W-1:0] rnd_ts();
		return TS_W'({$urandom(), $urandom()});
	endfunction

	function automatic logic [TXN_W-1:0] rnd_txn();
		return TXN_W'($urandom_range(0, 63));
	endfunction

	initial begin
		logic [TS_W-1:0] base, t;
		clear_model();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		// directed: rejects on empty, reads, commits, waiters, full buffer
		pending_reqs.push_back(mk(OP_WRITE, 5, 0, 0));
		pending_reqs.push_back(mk(OP_ABORT, 5, 63, 0));
		pending_reqs.push_back(mk(OP_READ, 0, 1, 0));
		pending_reqs.push_back(mk(OP_PREWRITE, 10, 2, 0));
		pending_reqs.push_back(mk(OP_READ, 20, 3, 0));
		pending_reqs.push_back(mk(OP_PREWRITE, 30, 4, 0));
		pending_reqs.push_back(mk(OP_PREWRITE, 30, 5, 0));
		pending_reqs.push_back(mk(OP_PREWRITE, 5, 6, 0));
		pending_reqs.push_back(mk(OP_WRITE, 10, 7, 0));
		pending_reqs.push_back(mk(OP_WRITE, 10, 8, 0));
		pending_reqs.push_back(mk(OP_READ, 5, 9, 0));
		pending_reqs.push_back(mk(OP_WRITE, 35, 10, 0));
		pending_reqs.push_back(mk(OP_PREWRITE, 40, 11, 0));
		for (int i = 0; i < 9; i++)
			pending_reqs.push_back(mk(OP_READ, 50 + i, TXN_W'(12 + i), 0));
		pending_reqs.push_back(mk(OP_ABORT, 40, 30, 0));
		pending_reqs.push_back(mk(OP_PREWRITE, {TS_W{1'b1}}, 31, {TS_W{1'b1}}));
		pending_reqs.push_back(mk(OP_WRITE, {TS_W{1'b1}}, 32, {TS_W{1'b1}}));
		wait (pending_reqs.size() == 0 && expected_replies.size() == 0);
		repeat (60) @(posedge clk);
		// random phase: the history is not reset after the max commit above; stamps
		// keep rising from a fresh base in prewrite/commit rounds
		base = 100;
		for (int k = 0; k < 135; k++) begin
			int nr;
			base = base + $urandom_range(1, 40);
			pending_reqs.push_back(mk(OP_PREWRITE, base, rnd_txn(),
				base - $urandom_range(0, 200)));
			nr = $urandom_range(0, 3);
			for (int j = 0; j < nr; j++) begin
				t = base - 150 + $urandom_range(0, 300);
				pending_reqs.push_back(mk(op_t'($urandom_range(0, 1)), t,
					rnd_txn(), base - $urandom_range(0, 300)));
			end
			if ($urandom_range(0, 9) == 0)
				pending_reqs.push_back(mk(op_t'($urandom_range(0, 3)), rnd_ts(),
					rnd_txn(), rnd_ts()));
			pending_reqs.push_back(mk($urandom_range(0, 4) == 0 ? OP_ABORT : OP_WRITE,
				base + $urandom_range(0, 3), rnd_txn(),
				base - $urandom_range(0, 300)));
			if (k == 100) begin
				wait (pending_reqs.size() == 0);
				quiet = 1;
			end
		end
		wait (pending_reqs.size() == 0 && expected_replies.size() == 0);
		repeat (100) @(posedge clk);
		stim_done = 1;
	end

	always @(posedge clk) begin
		if (stim_done) begin
			$display("covered %0d result words, %0d of them wakeups", n_words, n_wakes);
			if (errors == 0)
				$display("TEST PASSED");
			else
				$display("TEST FAILED");
			$finish;
		end else if (cycles > 1000000) begin
			$display("timeout with %0d results outstanding", expected_replies.size());
			$display("TEST FAILED");
			$finish;
		end
	end
endmodule
`default_nettype wire
